>>> rtl/hslrgb_pkg.sv
`timescale 1ns / 1ps

package hslrgb_pkg;

  localparam int unsigned ColorW = 16;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned HueW   = 6;
  localparam int unsigned SatW   = 3;
  localparam int unsigned LumW   = 7;
  localparam int unsigned AsW    = 10;  // (127 - |2l-127|) * sat, at most 889
  localparam int unsigned TermW  = 16;  // terms over the common denominator 56896
  localparam int unsigned QuotW  = 18;  // numerator * 255 / 64, at most 226695

  // 56896 = 889 * 64: shift out 64, then divide by 889 with a ceiling reciprocal.
  // Exact for every quotient input below 2^28 / 761.
  localparam int unsigned DenShift   = 6;
  localparam int unsigned RecipW     = 19;
  localparam int unsigned RecipShift = 28;
  localparam logic [RecipW-1:0] Recip889 = 19'd301953;
  localparam int unsigned ProdW      = QuotW + RecipW;

  localparam int unsigned QueueDepthDef = 2;

  typedef enum logic [2:0] {
    SecRedGreenUp  = 3'd0,
    SecGreenRedDn  = 3'd1,
    SecGreenBlueUp = 3'd2,
    SecBlueGreenDn = 3'd3,
    SecBlueRedUp   = 3'd4,
    SecRedBlueDn   = 3'd5
  } sector_e;

  typedef struct packed {
    sector_e            sector;
    logic [TermW-1:0]   cd;
    logic [TermW-1:0]   xd;
    logic [TermW-1:0]   md;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> rtl/hslrgb_front.sv
`timescale 1ns / 1ps

module hslrgb_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [hslrgb_pkg::ColorW-1:0] in_word_i,
  input  hslrgb_pkg::q_stat_t         q_stat_i,
  output logic                        push_o,
  output hslrgb_pkg::q_entry_t        push_entry_o
);

  localparam int unsigned AsW = hslrgb_pkg::AsW;

  logic                          v_q, v_d;
  logic [hslrgb_pkg::ColorW-1:0] word_q;

  logic [hslrgb_pkg::HueW-1:0]  hue;
  logic [hslrgb_pkg::SatW-1:0]  sat;
  logic [hslrgb_pkg::LumW-1:0]  lum;
  logic [7:0]                   dbl;
  logic [6:0]                   dev;
  logic [6:0]                   a;
  logic [hslrgb_pkg::AsW-1:0]   as_p;
  logic [7:0]                   h3;
  logic [5:0]                   tdev;
  logic [5:0]                   w;
  logic [14:0]                  asw;
  logic [15:0]                  lum448;

  assign push_o     = v_q && !q_stat_i.full;
  assign in_ready_o = !v_q || push_o;

  always_comb begin
    v_d = v_q;
    if (in_valid_i && in_ready_o) begin
      v_d = 1'b1;
    end else if (push_o) begin
      v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      word_q <= in_word_i;
    end
  end

  // Lightness zero gives a zero chroma and zero m, so black falls out of the terms.
  always_comb begin
    hue  = word_q[5:0];
    sat  = word_q[8:6];
    lum  = word_q[15:9];
    dbl  = {lum, 1'b0};
    dev  = (dbl >= 8'd127) ? 7'(dbl - 8'd127) : 7'(8'd127 - dbl);
    a    = 7'd127 - dev;
    as_p = AsW'(a) * AsW'(sat);
    h3   = 8'(hue) * 8'd3;
    tdev = (h3[5:0] >= 6'd32) ? (h3[5:0] - 6'd32) : (6'd32 - h3[5:0]);
    w    = 6'd32 - tdev;
    asw  = 15'(as_p) * 15'(w);
    lum448 = 16'(lum) * 16'd448;
    push_entry_o.sector = hslrgb_pkg::sector_e'(h3[7:5]);
    push_entry_o.cd     = {as_p, 6'b0};
    push_entry_o.xd     = {asw, 1'b0};
    push_entry_o.md     = lum448 - {1'b0, as_p, 5'b0};
  end

endmodule

>>> rtl/hslrgb_queue.sv
`timescale 1ns / 1ps

module hslrgb_queue #(
  parameter int unsigned Depth = hslrgb_pkg::QueueDepthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  hslrgb_pkg::q_entry_t push_entry_i,
  input  logic                 pop_i,
  output hslrgb_pkg::q_entry_t pop_entry_o,
  output hslrgb_pkg::q_stat_t  stat_o
);

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  hslrgb_pkg::q_entry_t entry_q [Depth];
  logic [IdxW-1:0]      wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]      cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign pop_entry_o  = entry_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == IdxW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == IdxW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= push_entry_i;
    end
  end

endmodule

>>> rtl/hslrgb_back.sv
`timescale 1ns / 1ps

module hslrgb_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hslrgb_pkg::q_stat_t         q_stat_i,
  input  hslrgb_pkg::q_entry_t        entry_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [hslrgb_pkg::ChanW-1:0] red_o,
  output logic [hslrgb_pkg::ChanW-1:0] green_o,
  output logic [hslrgb_pkg::ChanW-1:0] blue_o
);

  localparam int unsigned TermW = hslrgb_pkg::TermW;
  localparam int unsigned QuotW = hslrgb_pkg::QuotW;
  localparam int unsigned ProdW = hslrgb_pkg::ProdW;
  localparam int unsigned NumW  = TermW + 9;
  localparam int unsigned Sh    = hslrgb_pkg::RecipShift;
  localparam int unsigned Ds    = hslrgb_pkg::DenShift;

  logic                 v1_q, v2_q;
  logic                 en1, en2;
  logic [QuotW-1:0]     m_q [3];
  logic [ProdW-1:0]     p_q [3];
  logic [TermW-1:0]     v [3];
  logic [QuotW-1:0]     m_d [3];

  assign en2   = !v2_q || out_ready_i;
  assign en1   = !v1_q || en2;
  assign pop_o = en1 && !q_stat_i.empty;

  // Channel picks c, x or zero by hue sector.
  always_comb begin
    unique case (entry_i.sector)
      hslrgb_pkg::SecRedGreenUp: begin
        v[0] = entry_i.cd; v[1] = entry_i.xd; v[2] = '0;
      end
      hslrgb_pkg::SecGreenRedDn: begin
        v[0] = entry_i.xd; v[1] = entry_i.cd; v[2] = '0;
      end
      hslrgb_pkg::SecGreenBlueUp: begin
        v[0] = '0; v[1] = entry_i.cd; v[2] = entry_i.xd;
      end
      hslrgb_pkg::SecBlueGreenDn: begin
        v[0] = '0; v[1] = entry_i.xd; v[2] = entry_i.cd;
      end
      hslrgb_pkg::SecBlueRedUp: begin
        v[0] = entry_i.xd; v[1] = '0; v[2] = entry_i.cd;
      end
      default: begin
        v[0] = entry_i.cd; v[1] = '0; v[2] = entry_i.xd;
      end
    endcase
  end

  // (v + m) * 255, then drop the factor 64 of the denominator.
  always_comb begin
    logic [NumW-1:0] s;
    logic [NumW-1:0] n;
    for (int i = 0; i < 3; i++) begin
      s      = NumW'(v[i]) + NumW'(entry_i.md);
      n      = (s << 8) - s;
      m_d[i] = n[QuotW+Ds-1:Ds];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= !q_stat_i.empty;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      m_q <= m_d;
    end
    if (en2 && v1_q) begin
      for (int i = 0; i < 3; i++) begin
        p_q[i] <= ProdW'(m_q[i]) * ProdW'(hslrgb_pkg::Recip889);
      end
    end
  end

  assign out_valid_o = v2_q;
  assign red_o       = p_q[0][Sh+hslrgb_pkg::ChanW-1:Sh];
  assign green_o     = p_q[1][Sh+hslrgb_pkg::ChanW-1:Sh];
  assign blue_o      = p_q[2][Sh+hslrgb_pkg::ChanW-1:Sh];

endmodule

>>> rtl/packed_hsl_to_rgb_unit.sv
`timescale 1ns / 1ps
// channel  dir  payload (lsb first)
// s_axis   in   tdata[15:0]  = color_word
// m_axis   out  tdata[23:0]  = red, green, blue
//
// One color per cycle sustained while m_axis_tready stays high; a result is valid
// once its transfer has passed the input register (loaded at the transfer), then
// the queue entry, sum stage and reciprocal multiply stage.
// The divide by 889 is a 18x19 multiply per channel, which sets the back depth.
// Reset clears all valid flags and queue pointers; payload is not reset.
// A stalled output backs up the back stages, then the queue, then s_axis_tready.

module packed_hsl_to_rgb_unit #(
  parameter int unsigned QueueDepth = hslrgb_pkg::QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // color_word[15:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);

  hslrgb_pkg::q_stat_t  q_stat;
  hslrgb_pkg::q_entry_t push_entry, pop_entry;
  logic                 push, pop;

  hslrgb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_word_i    (s_axis_tdata),
    .q_stat_i     (q_stat),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  hslrgb_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .pop_entry_o  (pop_entry),
    .stat_o       (q_stat)
  );

  hslrgb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .entry_i     (pop_entry),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .red_o       (m_axis_tdata[7:0]),
    .green_o     (m_axis_tdata[15:8]),
    .blue_o      (m_axis_tdata[23:16])
  );

endmodule

>>> rtl/hslrgb_checker.sv
`timescale 1ns / 1ps

module hslrgb_checker #(
  parameter int unsigned QueueDepth = hslrgb_pkg::QueueDepthDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // input register + queue + two back stages
  localparam int unsigned Cap  = QueueDepth + 3;
  localparam int unsigned OutW = $clog2(Cap + 1);

  logic [OutW-1:0] outst_q;
  logic            in_xfer, out_xfer;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      outst_q <= outst_q + 1'b1;
    end else if (out_xfer && !in_xfer) begin
      outst_q <= outst_q - 1'b1;
    end
  end

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("m_axis_tvalid dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("m_axis_tdata changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> outst_q != '0)
    else $error("result shown with no color in flight");

  a_cap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outst_q == OutW'(Cap) |-> !s_axis_tready)
    else $error("transfer taken with every stage full");

  a_in_data_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outst_q <= OutW'(Cap))
    else $error("more colors in flight than storage, last input %h", s_axis_tdata);

endmodule

bind packed_hsl_to_rgb_unit hslrgb_checker #(.QueueDepth(QueueDepth)) u_hslrgb_checker (.*);
